FILE: rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, constants and helpers of the grid dda column raycaster.
// ----------------------------------------------------------------------------
package rcd_pkg;

  // default geometry
  localparam int MAP_SIZE_DEF      = 32;
  localparam int SCREEN_WIDTH_DEF  = 800;
  localparam int SCREEN_HEIGHT_DEF = 800;

  // divider widths: dividend covers |num| << 16, divisor covers the saturated perp
  localparam int DVD_W = 44;
  localparam int DVS_W = 49;

  // datapath widths fixed by the field widths
  localparam int COORD_W = 10;
  localparam int CAM_W   = 14;
  localparam int CFG_W   = 21;
  localparam int IDX_W   = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;

  // configuration reset values
  localparam logic [20:0]        POS_X_RST   = 21'd786432;
  localparam logic [20:0]        POS_Y_RST   = 21'd327680;
  localparam logic signed [17:0] DIR_X_RST   = -18'sd65536;
  localparam logic signed [17:0] DIR_Y_RST   = 18'sd0;
  localparam logic signed [17:0] PLANE_X_RST = 18'sd0;
  localparam logic signed [17:0] PLANE_Y_RST = 18'sd43254;

  // wall codes and colors
  localparam logic [2:0]  CODE_EMPTY = 3'd0;
  localparam logic [2:0]  CODE_RED   = 3'd1;
  localparam logic [2:0]  CODE_GREEN = 3'd2;
  localparam logic [2:0]  CODE_BLUE  = 3'd3;
  localparam logic [2:0]  CODE_WHITE = 3'd4;
  localparam logic [23:0] COLOR_RED    = 24'hFF0000;
  localparam logic [23:0] COLOR_GREEN  = 24'h00FF00;
  localparam logic [23:0] COLOR_BLUE   = 24'h0000FF;
  localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [23:0] COLOR_YELLOW = 24'hFFFF00;

  // one queued transaction, already classified by the front part
  typedef struct packed {
    logic       is_cast;
    logic       wr_ok;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [2:0] cell_value;
    logic [9:0] column;
  } item_t;

  // camera registers as seen by the back part
  typedef struct packed {
    logic [20:0]        pos_x;
    logic [20:0]        pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
  } cam_cfg_t;

  // wall code to rgb
  function automatic logic [23:0] color_of(input logic [2:0] code);
    logic [23:0] c;
    case (code)
      CODE_RED:   c = COLOR_RED;
      CODE_GREEN: c = COLOR_GREEN;
      CODE_BLUE:  c = COLOR_BLUE;
      CODE_WHITE: c = COLOR_WHITE;
      default:    c = COLOR_YELLOW;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/rcd_front.sv
// ----------------------------------------------------------------------------
// rcd_front
// Accepts input transactions, classifies them and holds them in a
// two-entry queue for the back part.
// ----------------------------------------------------------------------------
module rcd_front #(
  parameter int MAP_SIZE = rcd_pkg::MAP_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           operation,
  input  logic [4:0]     cell_x,
  input  logic [4:0]     cell_y,
  input  logic [2:0]     cell_value,
  input  logic [9:0]     column,
  output logic           q_valid,
  input  logic           q_ready,
  output rcd_pkg::item_t q_item
);
  import rcd_pkg::*;

  item_t      ent [2];
  item_t      cls;
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  // classify the incoming transaction
  always_comb begin
    cls.is_cast    = operation;
    cls.wr_ok      = (32'(cell_x) < MAP_SIZE) && (32'(cell_y) < MAP_SIZE);
    cls.cell_x     = cell_x;
    cls.cell_y     = cell_y;
    cls.cell_value = cell_value;
    cls.column     = column;
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = ent[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) ent[wptr] <= cls;
  end

endmodule

FILE: rtl/rcd_div.sv
// ----------------------------------------------------------------------------
// rcd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rcd_pkg::DVD_W-1:0] dividend,
  input  logic [rcd_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [rcd_pkg::DVD_W-1:0] quotient
);
  import rcd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] work;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  // trial subtraction
  always_comb begin
    shifted = {rem, work[DVD_W-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  assign quotient = work;

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      work <= dividend;
    end else if (cnt != '0) begin
      rem  <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      work <= {work[DVD_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/rcd_back.sv
// ----------------------------------------------------------------------------
// rcd_back
// Holds the map, clears it after reset, writes cells, and runs each cast: ray setup,
// step lengths, dda walk, distance, span and color, into an output register.
// ----------------------------------------------------------------------------
module rcd_back #(
  parameter int MAP_SIZE      = rcd_pkg::MAP_SIZE_DEF,
  parameter int SCREEN_WIDTH  = rcd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rcd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  rcd_pkg::item_t    q_item,
  input  rcd_pkg::cam_cfg_t cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [9:0]        out_column,
  output logic [9:0]        draw_start,
  output logic [9:0]        draw_end,
  output logic [23:0]       wall_color,
  output logic              hit_side
);
  import rcd_pkg::*;

  localparam int DEPTH    = MAP_SIZE * MAP_SIZE;
  localparam int AW       = $clog2(DEPTH);
  localparam int HALF     = SCREEN_HEIGHT / 2;
  localparam int LINE_MAX = 2 * SCREEN_HEIGHT;
  localparam int LINE_W   = $clog2(LINE_MAX + 1);
  localparam int SPAN_W   = LINE_W + 1;
  localparam logic signed [COORD_W-1:0] MAP_LIM = COORD_W'(MAP_SIZE);

  // divide by the screen width through a reciprocal multiply,
  // exact for any |plane * cam| below 2^RCP_IN_W
  localparam int RCP_IN_W = 30;
  localparam int RCP_MW   = RCP_IN_W + 1;
  localparam int RCP_PW   = 2 * RCP_IN_W + 1;
  localparam int RCP_SH   = RCP_IN_W + $clog2(SCREEN_WIDTH);
  localparam logic [RCP_MW-1:0] RCP_MUL =
    RCP_MW'(((64'd1 << RCP_SH) + 64'(SCREEN_WIDTH - 1)) / 64'(SCREEN_WIDTH));

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_MUL   = 14'b00000000000100,
    S_RX    = 14'b00000000001000,
    S_RY    = 14'b00000000010000,
    S_DX    = 14'b00000000100000,
    S_DY    = 14'b00000001000000,
    S_DIV   = 14'b00000010000000,
    S_SIDE  = 14'b00000100000000,
    S_STEP  = 14'b00001000000000,
    S_CHECK = 14'b00010000000000,
    S_PERP  = 14'b00100000000000,
    S_LINE  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    OP_DX   = 2'd0,
    OP_DY   = 2'd1,
    OP_PERP = 2'd2,
    OP_LINE = 2'd3
  } div_op_t;

  state_t  state;
  div_op_t div_op;

  // map memory
  logic [2:0]    mem [DEPTH];
  logic [2:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [2:0]    mem_wd;
  logic [AW-1:0] clr_addr;

  // divider interface
  logic             div_go;
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  // cast datapath
  logic [9:0]                col_r;
  logic signed [CAM_W-1:0]   cam;
  logic signed [31:0]        prod_x;
  logic signed [31:0]        prod_y;
  logic [RCP_IN_W-1:0]       mag_px;
  logic [RCP_IN_W-1:0]       mag_py;
  logic [RCP_PW-1:0]         rcp_px;
  logic [RCP_PW-1:0]         rcp_py;
  logic [31:0]               quo_px;
  logic [31:0]               quo_py;
  logic signed [32:0]        rx;
  logic signed [32:0]        ry;
  logic [31:0]               mag_rx;
  logic [31:0]               mag_ry;
  logic [31:0]               dx;
  logic [31:0]               dy;
  logic [48:0]               sdx;
  logic [48:0]               sdy;
  logic [48:0]               side_px;
  logic [48:0]               side_py;
  logic signed [COORD_W-1:0] mx;
  logic signed [COORD_W-1:0] my;
  logic signed [COORD_W-1:0] nx;
  logic signed [COORD_W-1:0] ny;
  logic                      take_x;
  logic                      side;
  logic [2:0]                code;
  logic [2:0]                cell_v;
  logic                      in_map_n;
  logic                      in_map_c;
  logic [49:0]               sum_x;
  logic [49:0]               sum_y;
  logic [48:0]               sat_x;
  logic [48:0]               sat_y;
  logic signed [27:0]        num;
  logic [26:0]               mag_num;
  logic [48:0]               perp;
  logic [LINE_W-1:0]         line;
  logic [SPAN_W-1:0]         half_line;
  logic [SPAN_W-1:0]         start_v;
  logic [SPAN_W-1:0]         end_v;
  logic [23:0]               color_v;

  rcd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_ready = (state == S_IDLE);

  // divider issue: states that start a pass when no saturation shortcut applies
  assign div_go = ((state == S_DX) && (rx != 33'sd0))
               || ((state == S_DY) && (ry != 33'sd0))
               || ((state == S_PERP) && ((side ? ry : rx) != 33'sd0))
               || ((state == S_LINE) && (perp != '0));

  // ray and step arithmetic
  always_comb begin
    cam     = CAM_W'({col_r, 1'b0}) - CAM_W'(SCREEN_WIDTH);
    mag_px  = prod_x[31] ? RCP_IN_W'(-prod_x) : RCP_IN_W'(prod_x);
    mag_py  = prod_y[31] ? RCP_IN_W'(-prod_y) : RCP_IN_W'(prod_y);
    quo_px  = 32'(rcp_px >> RCP_SH);
    quo_py  = 32'(rcp_py >> RCP_SH);
    mag_rx  = rx[32] ? 32'(-rx) : 32'(rx);
    mag_ry  = ry[32] ? 32'(-ry) : 32'(ry);
    side_px = 49'(rx[32] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]})
              * 49'(dx);
    side_py = 49'(ry[32] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]})
              * 49'(dy);
    sum_x   = {1'b0, sdx} + {18'b0, dx};
    sum_y   = {1'b0, sdy} + {18'b0, dy};
    sat_x   = (sum_x > 50'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : sum_x[48:0];
    sat_y   = (sum_y > 50'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : sum_y[48:0];
  end

  // next dda cell and its map address
  always_comb begin
    take_x   = (sdx < sdy);
    nx       = take_x ? (rx[32] ? mx - 10'sd1 : mx + 10'sd1) : mx;
    ny       = take_x ? my : (ry[32] ? my - 10'sd1 : my + 10'sd1);
    in_map_n = (nx >= 10'sd0) && (ny >= 10'sd0) && (nx < MAP_LIM) && (ny < MAP_LIM);
    in_map_c = (mx >= 10'sd0) && (my >= 10'sd0) && (mx < MAP_LIM) && (my < MAP_LIM);
    rd_addr  = in_map_n ? AW'(32'(nx[COORD_W-1:0]) * MAP_SIZE + 32'(ny[COORD_W-1:0])) : '0;
    cell_v   = in_map_c ? rd_data : CODE_RED;
  end

  // distance numerator on the crossed axis
  always_comb begin
    if (!side) begin
      num = {{2{mx[COORD_W-1]}}, mx, 16'b0} - 28'({7'b0, cfg.pos_x})
            + (rx[32] ? 28'sh10000 : 28'sh0);
    end else begin
      num = {{2{my[COORD_W-1]}}, my, 16'b0} - 28'({7'b0, cfg.pos_y})
            + (ry[32] ? 28'sh10000 : 28'sh0);
    end
    mag_num = num[27] ? 27'(-num) : 27'(num);
  end

  // span clamp and color
  always_comb begin
    half_line = SPAN_W'(line[LINE_W-1:1]);
    start_v   = (half_line > SPAN_W'(HALF)) ? '0 : SPAN_W'(HALF) - half_line;
    end_v     = SPAN_W'(HALF) + half_line;
    if (end_v >= SPAN_W'(SCREEN_HEIGHT)) end_v = SPAN_W'(SCREEN_HEIGHT - 1);
    color_v   = color_of(code);
    if (side) color_v = {1'b0, color_v[23:1]};
  end

  // memory write source: clearing pass or cell write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr;
    mem_wd = CODE_EMPTY;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if ((state == S_IDLE) && q_valid && !q_item.is_cast && q_item.wr_ok) begin
      mem_we = 1'b1;
      mem_wa = AW'(32'(q_item.cell_x) * MAP_SIZE + 32'(q_item.cell_y));
      mem_wd = q_item.cell_value;
    end
  end

  // map memory port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_addr];
  end

  // cast sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= div_go;
      out_valid <= (state == S_OUT) || (out_valid && !out_ready);
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
          else clr_addr <= clr_addr + AW'(1);
        end
        S_IDLE: begin
          if (q_valid && q_item.is_cast) begin
            col_r <= q_item.column;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_x <= 32'(cfg.plane_x) * 32'(cam);
          prod_y <= 32'(cfg.plane_y) * 32'(cam);
          state  <= S_RX;
        end
        S_RX: begin
          rcp_px <= RCP_PW'(mag_px) * RCP_PW'(RCP_MUL);
          rcp_py <= RCP_PW'(mag_py) * RCP_PW'(RCP_MUL);
          state  <= S_RY;
        end
        S_RY: begin
          rx    <= prod_x[31] ? 33'(cfg.dir_x) - $signed({1'b0, quo_px})
                              : 33'(cfg.dir_x) + $signed({1'b0, quo_px});
          ry    <= prod_y[31] ? 33'(cfg.dir_y) - $signed({1'b0, quo_py})
                              : 33'(cfg.dir_y) + $signed({1'b0, quo_py});
          state <= S_DX;
        end
        S_DX: begin
          if (rx == 33'sd0) begin
            dx    <= 32'hFFFF_FFFF;
            state <= S_DY;
          end else begin
            div_dvd <= DVD_W'(33'h1_0000_0000);
            div_dvs <= DVS_W'(mag_rx);
            div_op  <= OP_DX;
            state   <= S_DIV;
          end
        end
        S_DY: begin
          if (ry == 33'sd0) begin
            dy    <= 32'hFFFF_FFFF;
            state <= S_SIDE;
          end else begin
            div_dvd <= DVD_W'(33'h1_0000_0000);
            div_dvs <= DVS_W'(mag_ry);
            div_op  <= OP_DY;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            unique case (div_op)
              OP_DX: begin
                dx    <= (div_q[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                state <= S_DY;
              end
              OP_DY: begin
                dy    <= (div_q[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
                state <= S_SIDE;
              end
              OP_PERP: begin
                perp  <= DVS_W'(div_q);
                state <= S_LINE;
              end
              OP_LINE: begin
                line  <= (div_q > DVD_W'(LINE_MAX)) ? LINE_W'(LINE_MAX) : LINE_W'(div_q);
                state <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SIDE: begin
          sdx   <= 49'(side_px[48:16]);
          sdy   <= 49'(side_py[48:16]);
          mx    <= $signed(COORD_W'(cfg.pos_x[20:16]));
          my    <= $signed(COORD_W'(cfg.pos_y[20:16]));
          state <= S_STEP;
        end
        S_STEP: begin
          if (take_x) begin
            sdx  <= sat_x;
            mx   <= nx;
            side <= 1'b0;
          end else begin
            sdy  <= sat_y;
            my   <= ny;
            side <= 1'b1;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cell_v != CODE_EMPTY) begin
            code  <= cell_v;
            state <= S_PERP;
          end else begin
            state <= S_STEP;
          end
        end
        S_PERP: begin
          if ((side ? ry : rx) == 33'sd0) begin
            perp  <= 49'h1_0000_0000_0000;
            state <= S_LINE;
          end else begin
            div_dvd <= DVD_W'({mag_num, 16'b0});
            div_dvs <= DVS_W'(side ? mag_ry : mag_rx);
            div_op  <= OP_PERP;
            state   <= S_DIV;
          end
        end
        S_LINE: begin
          if (perp == '0) begin
            line  <= LINE_W'(LINE_MAX);
            state <= S_OUT;
          end else begin
            div_dvd <= DVD_W'(SCREEN_HEIGHT * 65536);
            div_dvs <= perp;
            div_op  <= OP_LINE;
            state   <= S_DIV;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_column <= col_r;
            draw_start <= 10'(start_v);
            draw_end   <= 10'(end_v);
            wall_color <= color_v;
            hit_side   <= side;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/grid_dda_column_raycaster.sv
// flow: a queued map write is done while the cast engine is idle; a cast result is
//   registered after the dda walk and up to four passes of the shared serial divider
//   (a zero ray component skips a pass).
// casts: one cast at a time, the next is taken once the result is registered; the queue holds two.
// reset: synchronous; clears control and loads the camera reset values, then a
//   clearing pass over all MAP_SIZE*MAP_SIZE cells zeroes the map before items run.
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster
// Column raycaster over a square wall map: camera registers, input queue,
// cast engine with map memory.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster #(
  parameter int MAP_SIZE      = rcd_pkg::MAP_SIZE_DEF,
  parameter int SCREEN_WIDTH  = rcd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rcd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rcd_pkg::IDX_W-1:0] cfg_index,
  input  logic [rcd_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [4:0]                cell_x,
  input  logic [4:0]                cell_y,
  input  logic [2:0]                cell_value,
  input  logic [9:0]                column,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [9:0]                out_column,
  output logic [9:0]                draw_start,
  output logic [9:0]                draw_end,
  output logic [23:0]               wall_color,
  output logic                      hit_side
);
  import rcd_pkg::*;

  cam_cfg_t cfg;
  item_t    q_item;
  logic     q_valid;
  logic     q_ready;

  // camera registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x   <= POS_X_RST;
      cfg.pos_y   <= POS_Y_RST;
      cfg.dir_x   <= DIR_X_RST;
      cfg.dir_y   <= DIR_Y_RST;
      cfg.plane_x <= PLANE_X_RST;
      cfg.plane_y <= PLANE_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_X:   cfg.pos_x   <= cfg_data[20:0];
        REG_POS_Y:   cfg.pos_y   <= cfg_data[20:0];
        REG_DIR_X:   cfg.dir_x   <= $signed(cfg_data[17:0]);
        REG_DIR_Y:   cfg.dir_y   <= $signed(cfg_data[17:0]);
        REG_PLANE_X: cfg.plane_x <= $signed(cfg_data[17:0]);
        REG_PLANE_Y: cfg.plane_y <= $signed(cfg_data[17:0]);
        default: ;
      endcase
    end
  end

  rcd_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .column     (column),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  rcd_back #(
    .MAP_SIZE      (MAP_SIZE),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .cfg        (cfg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_column (out_column),
    .draw_start (draw_start),
    .draw_end   (draw_end),
    .wall_color (wall_color),
    .hit_side   (hit_side)
  );

endmodule

FILE: rtl/rcd_checker.sv
// ----------------------------------------------------------------------------
// rcd_checker
// Port-level checks on the result channel of the raycaster.
// ----------------------------------------------------------------------------
module rcd_checker #(
  parameter int SCREEN_HEIGHT = rcd_pkg::SCREEN_HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_column,
  input logic [9:0]  draw_start,
  input logic [9:0]  draw_end,
  input logic [23:0] wall_color,
  input logic        hit_side
);

  // a stalled result transaction stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_column) && $stable(draw_start)
      && $stable(draw_end) && $stable(wall_color) && $stable(hit_side))
    else $error("result payload changed while stalled");

  // y-side hits carry the halved color
  a_shade: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_side |-> !wall_color[23])
    else $error("y-side color not halved");

  // span is ordered and on screen
  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (SCREEN_HEIGHT > 1024)
      || ((draw_start <= draw_end) && (32'(draw_end) < SCREEN_HEIGHT)))
    else $error("wall span out of order or off screen");

endmodule

bind grid_dda_column_raycaster rcd_checker #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_chk (.*);

FILE: tb/grid_dda_column_raycaster_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster_test
// Drives cell writes and column casts with random gaps on both handshakes,
// predicts each wall span, color and side in a DDA walk of its own and
// compares every result transaction in order. Camera registers change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster_test;
  import rcd_pkg::*;

  localparam int MSZ = 32;
  localparam int SW = 800;
  localparam int SH = 800;
  localparam longint SUM_SAT = 64'h1_0000_0000_0000;
  localparam longint DELTA_SAT = 64'hFFFF_FFFF;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST = 1'b1;
  localparam longint CYCLE_LIMIT = 64'd4_000_000;

  typedef struct packed {
    logic       op;
    logic [4:0] cx;
    logic [4:0] cy;
    logic [2:0] val;
    logic [9:0] col;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  start;
    logic [9:0]  stop;
    logic [23:0] color;
    logic        side;
  } span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [4:0] cell_x = '0;
  logic [4:0] cell_y = '0;
  logic [2:0] cell_value = '0;
  logic [9:0] column = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_column, draw_start, draw_end;
  logic [23:0] wall_color;
  logic hit_side;

  grid_dda_column_raycaster dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [2:0] wall_map [MSZ][MSZ];
  logic [20:0] cam_px, cam_py;
  logic signed [17:0] cam_dx, cam_dy, cam_plx, cam_ply;

  cmd_t pending_cmds[$];
  span_t expected_spans[$];
  int mismatches = 0;
  longint cycles = 0;
  int sent = 0;
  int hold_off = 0;
  bit long_hold_req = 0;

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint step_length(longint r);
    longint a, q;
    a = abs64(r);
    if (a == 0) return DELTA_SAT;
    q = (64'd1 << 32) / a;
    return q > DELTA_SAT ? DELTA_SAT : q;
  endfunction

  function automatic longint add_sat(longint a, longint b);
    return (a + b) > SUM_SAT ? SUM_SAT : a + b;
  endfunction

  function automatic logic [2:0] map_code(longint x, longint y);
    if (x < 0 || y < 0 || x >= MSZ || y >= MSZ) return CODE_RED;
    return wall_map[x][y];
  endfunction

  function automatic span_t cast_column(logic [9:0] c);
    longint cam, rx, ry, mx, my, sxd, syd, fx, fy, dx, dy, sdx, sdy;
    longint num, ray, perp, line, st, en;
    logic [2:0] code;
    logic [23:0] rgb;
    int side;
    span_t r;
    code = CODE_EMPTY;
    side = 0;
    cam = 2 * longint'(c) - SW;
    rx = longint'(cam_dx) + (longint'(cam_plx) * cam) / SW;
    ry = longint'(cam_dy) + (longint'(cam_ply) * cam) / SW;
    mx = longint'(cam_px) >>> 16;
    my = longint'(cam_py) >>> 16;
    fx = longint'(cam_px) & 16'hFFFF;
    fy = longint'(cam_py) & 16'hFFFF;
    dx = step_length(rx);
    dy = step_length(ry);
    if (rx < 0) begin sxd = -1; sdx = (fx * dx) >>> 16; end
    else begin sxd = 1; sdx = ((65536 - fx) * dx) >>> 16; end
    if (ry < 0) begin syd = -1; sdy = (fy * dy) >>> 16; end
    else begin syd = 1; sdy = ((65536 - fy) * dy) >>> 16; end
    for (int n = 0; n < 4 * (MSZ + 32); n++) begin
      if (sdx < sdy) begin
        sdx = add_sat(sdx, dx); mx += sxd; side = 0;
      end else begin
        sdy = add_sat(sdy, dy); my += syd; side = 1;
      end
      code = map_code(mx, my);
      if (code != CODE_EMPTY) break;
    end
    if (side == 0) begin
      num = mx * 65536 - longint'(cam_px) + (sxd < 0 ? 65536 : 0);
      ray = rx;
    end else begin
      num = my * 65536 - longint'(cam_py) + (syd < 0 ? 65536 : 0);
      ray = ry;
    end
    perp = (ray == 0) ? SUM_SAT : (abs64(num) << 16) / abs64(ray);
    if (perp == 0) line = 2 * SH;
    else begin
      line = (longint'(SH) << 16) / perp;
      if (line > 2 * SH) line = 2 * SH;
    end
    st = SH / 2 - line / 2;
    if (st < 0) st = 0;
    en = SH / 2 + line / 2;
    if (en >= SH) en = SH - 1;
    case (code)
      CODE_RED:   rgb = 24'hFF0000;
      CODE_GREEN: rgb = 24'h00FF00;
      CODE_BLUE:  rgb = 24'h0000FF;
      CODE_WHITE: rgb = 24'hFFFFFF;
      default:    rgb = 24'hFFFF00;
    endcase
    if (side == 1) rgb = rgb >> 1;
    r.col = c;
    r.start = st[9:0];
    r.stop = en[9:0];
    r.color = rgb;
    r.side = side[0];
    return r;
  endfunction

  // driver: one transaction per pending item, with random gaps between some of them
  int send_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) begin
      cmd_t c;
      c = pending_cmds.pop_front();
      if (c.op == OP_CAST) expected_spans.push_back(cast_column(c.col));
      else wall_map[c.cx][c.cy] = c.val;
      sent <= sent + 1;
    end
    if (!rst) begin
      if (in_valid && !in_ready) begin
        // hold payload
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else begin
        // next pending item, the accepted one is already gone
        if (pending_cmds.size() > 0) begin
          cmd_t n;
          n = pending_cmds[0];
          in_valid <= 1'b1;
          operation <= n.op;
          cell_x <= n.cx;
          cell_y <= n.cy;
          cell_value <= n.val;
          column <= n.col;
          send_gap <= (in_valid && in_ready && $urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 18) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result transaction with the oldest expectation
  int recv_gap = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_spans.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result column %0d", out_column);
      end else begin
        span_t e;
        e = expected_spans.pop_front();
        if (e != {out_column, draw_start, draw_end, wall_color, hit_side}) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp col %0d %0d..%0d %h side %0d got col %0d %0d..%0d %h side %0d",
                     e.col, e.start, e.stop, e.color, e.side, out_column, draw_start,
                     draw_end, wall_color, hit_side);
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold_req && hold_off == 0) begin
      hold_off <= 3000;
      long_hold_req <= 0;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= (hold_off == 1);
    end else if (out_valid && out_ready) begin
      recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
      hold_off <= recv_gap;
      out_ready <= (recv_gap == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL grid_dda_column_raycaster");
      $finish;
    end
  end

  function automatic cmd_t cmd_write(int x, int y, int v);
    cmd_t c;
    c = '0;
    c.op = OP_WRITE; c.cx = 5'(x); c.cy = 5'(y); c.val = 3'(v);
    return c;
  endfunction

  function automatic cmd_t cmd_cast(int col);
    cmd_t c;
    c = 24'($urandom);
    c.op = OP_CAST; c.col = 10'(col);
    return c;
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_spans.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_POS_X:   cam_px = val;
      REG_POS_Y:   cam_py = val;
      REG_DIR_X:   cam_dx = val[17:0];
      REG_DIR_Y:   cam_dy = val[17:0];
      REG_PLANE_X: cam_plx = val[17:0];
      default:     cam_ply = val[17:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random mix of map writes and casts; cast columns kept mostly on screen
  task automatic random_phase(int count, bit sparse);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0)
        pending_cmds.push_back(cmd_write($urandom_range(0, 31), $urandom_range(0, 31),
                               (sparse && $urandom_range(0, 3) != 0) ? 0 :
                               $urandom_range(0, 7)));
      else
        pending_cmds.push_back(cmd_cast($urandom_range(0, 2) == 0 ?
                               $urandom_range(0, 1023) : $urandom_range(0, 799)));
    end
  endtask

  initial begin
    for (int x = 0; x < MSZ; x++)
      for (int y = 0; y < MSZ; y++) wall_map[x][y] = CODE_EMPTY;
    cam_px = POS_X_RST; cam_py = POS_Y_RST;
    cam_dx = DIR_X_RST; cam_dy = DIR_Y_RST;
    cam_plx = PLANE_X_RST; cam_ply = PLANE_Y_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty map, extremes of column, every wall code
    pending_cmds.push_back(cmd_cast(0));
    pending_cmds.push_back(cmd_cast(400));
    pending_cmds.push_back(cmd_cast(799));
    pending_cmds.push_back(cmd_cast(1023));
    for (int v = 0; v < 8; v++) pending_cmds.push_back(cmd_write(11 - v, 5, v));
    pending_cmds.push_back(cmd_write(31, 31, 7));
    pending_cmds.push_back(cmd_write(0, 0, 7));
    for (int k = 0; k < 6; k++) pending_cmds.push_back(cmd_cast(k * 160));
    pending_cmds.push_back(cmd_write(0, 0, 0));
    pending_cmds.push_back(cmd_write(31, 31, 0));
    // long receiver stall while casts keep coming
    long_hold_req = 1;
    for (int k = 0; k < 6; k++) pending_cmds.push_back(cmd_cast($urandom_range(0, 799)));
    drain();

    // axis-aligned rays: zero components and zero distance
    write_reg(REG_DIR_X, 21'h0);
    write_reg(REG_PLANE_X, 21'h0);
    write_reg(REG_DIR_Y, 21'h10000);
    write_reg(REG_PLANE_Y, 21'h0);
    write_reg(REG_POS_X, 21'h0A0000);
    write_reg(REG_POS_Y, 21'h0A8000);
    pending_cmds.push_back(cmd_cast(400));
    pending_cmds.push_back(cmd_cast(0));
    drain();

    // several camera settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      logic [CFG_W-1:0] px, py;
      case (ph)
        0: begin px = 21'h1FFFFF; py = 21'h1FFFFF; end
        1: begin px = '0; py = '0; end
        default: begin
          px = {5'($urandom_range(0, 31)), 16'($urandom)};
          py = {5'($urandom_range(0, 31)), 16'($urandom)};
        end
      endcase
      write_reg(REG_POS_X, px);
      write_reg(REG_POS_Y, py);
      write_reg(REG_DIR_X, ph == 0 ? 21'h20000 : ph == 1 ? 21'h1FFFF : 21'($urandom));
      write_reg(REG_DIR_Y, ph == 0 ? 21'h1FFFF : ph == 1 ? 21'h20000 : 21'($urandom));
      write_reg(REG_PLANE_X, ph == 0 ? 21'h1FFFF : 21'($urandom));
      write_reg(REG_PLANE_Y, ph == 1 ? 21'h20000 : 21'($urandom));
      random_phase(ph < 2 ? 60 : 155, ph[0]);
      if (ph == 4) long_hold_req = 1;
      drain();
    end

    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("PASS grid_dda_column_raycaster");
    end else begin
      $display("FAIL grid_dda_column_raycaster");
    end
    $finish;
  end
endmodule
